>>> rtl/rdsc_pkg.sv
package rdsc_pkg;

  // Field and register widths
  localparam int NUMBER_W    = 64;
  localparam int SYMBOL_W    = 8;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int NUM_SYMBOLS = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  // Base limits and digit store
  localparam int MAX_RADIX   = 16;
  localparam int DIGIT_DEPTH = 64;
  localparam int ADDR_W      = $clog2(DIGIT_DEPTH);

  // Divider: dividend bits retired per cycle and divider steps per digit
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = NUMBER_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Forbidden symbols
  localparam logic [SYMBOL_W-1:0] SIGN_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] SIGN_PLUS  = 8'h2B;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX         = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_STORE,
    ST_FETCH,
    ST_PRESENT,
    ST_ERROR
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic emit_digit;
    logic emit_error;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_base;
    logic step_last;
    logic quo_zero;
    logic store_full;
    logic ptr_zero;
    logic out_free;
  } dp_status_t;

  function automatic logic [SYMBOL_W-1:0] symbol_at(
    input logic [DIGIT_W-1:0]    idx,
    input logic [CFG_DATA_W-1:0] alpha_low,
    input logic [CFG_DATA_W-1:0] alpha_high
  );
    logic [CFG_DATA_W-1:0] word;
    word = idx[DIGIT_W-1] ? alpha_high : alpha_low;
    return word[idx[DIGIT_W-2:0]*SYMBOL_W +: SYMBOL_W];
  endfunction

endpackage

>>> rtl/rdsc_ctrl.sv
module rdsc_ctrl
  import rdsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.bad_base ? ST_ERROR : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.step_last) state_next = ST_STORE;
      end
      ST_STORE: begin
        state_next = (status.quo_zero || status.store_full) ? ST_FETCH : ST_DIVIDE;
      end
      ST_FETCH: begin
        state_next = ST_PRESENT;
      end
      ST_PRESENT: begin
        if (status.out_free) state_next = status.ptr_zero ? ST_IDLE : ST_FETCH;
      end
      ST_ERROR: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CHECK:   ;
      ST_DIVIDE:  cmd.div_step = 1'b1;
      ST_STORE:   cmd.store = 1'b1;
      ST_FETCH:   ;
      ST_PRESENT: cmd.emit_digit = status.out_free;
      ST_ERROR:   cmd.emit_error = status.out_free;
      default:    ;
    endcase
  end

endmodule

>>> rtl/rdsc_datapath.sv
module rdsc_datapath
  import rdsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [NUMBER_W-1:0]    number,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SYMBOL_W-1:0]    symbol,
  output logic                   last_digit,
  output logic                   bad_base,
  input  dp_cmd_t                cmd,
  output dp_status_t             status
);

  // Configuration registers
  logic [RADIX_W-1:0]    radix;
  logic [CFG_DATA_W-1:0] alpha_low;
  logic [CFG_DATA_W-1:0] alpha_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= '0;
      alpha_low  <= '0;
      alpha_high <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RADIX:         radix      <= cfg_data[RADIX_W-1:0];
        CFG_ALPHABET_LOW:  alpha_low  <= cfg_data;
        CFG_ALPHABET_HIGH: alpha_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Base check: radix range, sign symbols, repeated symbols in use
  logic [SYMBOL_W-1:0] sym [NUM_SYMBOLS];
  logic                base_bad;

  always_comb begin
    base_bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));
    for (int a = 0; a < NUM_SYMBOLS; a++) begin
      sym[a] = symbol_at(DIGIT_W'(a), alpha_low, alpha_high);
    end
    for (int a = 0; a < NUM_SYMBOLS; a++) begin
      if (RADIX_W'(a) < radix) begin
        if (sym[a] == SIGN_MINUS || sym[a] == SIGN_PLUS) base_bad = 1'b1;
        for (int b = 0; b < a; b++) begin
          if (sym[b] == sym[a]) base_bad = 1'b1;
        end
      end
    end
  end

  // Restoring divider, DIV_BITS dividend bits per cycle
  logic [NUMBER_W-1:0] dvd, dvd_next;
  logic [DIGIT_W-1:0]  rem, rem_next;
  logic [STEP_W-1:0]   step;
  logic [DIGIT_W:0]    trial;

  always_comb begin
    dvd_next = dvd;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial    = {rem_next, dvd_next[NUMBER_W-1]};
      dvd_next = {dvd_next[NUMBER_W-2:0], 1'b0};
      if (trial >= radix) begin
        trial       = trial - radix;
        dvd_next[0] = 1'b1;
      end
      rem_next = trial[DIGIT_W-1:0];
    end
  end

  // Digit store: remainders, least significant first
  logic [DIGIT_W-1:0] digit_mem [DIGIT_DEPTH];
  logic [ADDR_W-1:0]  wr_ptr;
  logic [ADDR_W-1:0]  rd_ptr;
  logic [DIGIT_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.store) digit_mem[wr_ptr] <= rem;
    rd_data <= digit_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (cmd.load) begin
      step   <= '0;
      wr_ptr <= '0;
    end else if (cmd.div_step) begin
      step <= step + STEP_W'(1);
    end else if (cmd.store) begin
      step   <= '0;
      wr_ptr <= wr_ptr + ADDR_W'(1);
      rd_ptr <= wr_ptr;
    end else if (cmd.emit_digit) begin
      rd_ptr <= rd_ptr - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd <= number;
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end else if (cmd.store) begin
      rem <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_digit || cmd.emit_error) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_digit) begin
      symbol     <= symbol_at(rd_data, alpha_low, alpha_high);
      last_digit <= (rd_ptr == '0);
      bad_base   <= 1'b0;
    end else if (cmd.emit_error) begin
      symbol     <= '0;
      last_digit <= 1'b1;
      bad_base   <= 1'b1;
    end
  end

  always_comb begin
    status.bad_base   = base_bad;
    status.step_last  = (step == STEP_W'(DIV_STEPS - 1));
    status.quo_zero   = (dvd == '0);
    status.store_full = (wr_ptr == ADDR_W'(DIGIT_DEPTH - 1));
    status.ptr_zero   = (rd_ptr == '0);
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

>>> rtl/radix_digit_string_converter.sv
// Channel  Dir  Signals                                Moves
// -------  ---  -------------------------------------  ----------------------------
// cfg      in   cfg_write, cfg_index, cfg_data         register write (radix, alphabet)
// in       in   in_valid, in_stall, number             one request: 64-bit number
// out      out  out_valid, out_stall, symbol,          one request per digit, most
//               last_digit, bad_base                   significant first
//
// Sequence: an invalid base gives a single error result per number. Otherwise each
// digit is produced by the divider steps of the 8-bit-per-cycle restoring divider
// and a store step, until the quotient is zero or the 64-entry digit store is full;
// then the digits are read back from the digit store through its registered port.
// Reset: rst is synchronous; it clears the state machine, the output valid and the
// configuration registers (radix 0, so the base reads invalid until configured).
// Stalls: a pending output holds under out_stall while the next number may be taken.
module radix_digit_string_converter
  import rdsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [NUMBER_W-1:0]    number,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SYMBOL_W-1:0]    symbol,
  output logic                   last_digit,
  output logic                   bad_base
);

  // Commands from the sequencer, status back from the datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: check base, divide per digit, store, then read digits back
  rdsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: config registers, base check, divider, digit store, output register
  rdsc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .number     (number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol     (symbol),
    .last_digit (last_digit),
    .bad_base   (bad_base),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

>>> rtl/rdsc_checker.sv
module rdsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] symbol,
  input logic       last_digit,
  input logic       bad_base
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(last_digit)
                               && $stable(bad_base))
    else $error("stalled result changed");

  // An error result stands alone with a zero symbol
  a_bad_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_base |-> last_digit && symbol == 8'd0)
    else $error("bad_base result malformed");

  // Stall input right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // Drop any result on reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind radix_digit_string_converter rdsc_checker u_rdsc_checker (.*);
